>>> src/ssla_pkg.sv
`timescale 1ns / 1ps

package ssla_pkg;

  localparam int RING_DEPTH = 16;
  localparam int CAL_POINTS = 7;

  localparam int SMP_W    = 10;
  localparam int DEN_W    = 10;
  localparam int KX_W     = 12;
  localparam int DELTAS_W = 56;
  localparam int SEGS     = DELTAS_W / 8;
  localparam int POS_W    = $clog2(RING_DEPTH);
  localparam int ADDR_W   = POS_W + 1;
  localparam int FILL_W   = $clog2(RING_DEPTH + 1);
  localparam int SUM_W    = 16 + POS_W + 1;
  localparam int DIV_W    = (SUM_W > 22) ? SUM_W : 22;
  localparam int CNT_W    = $clog2(DIV_W + 1);
  localparam int IDX_W    = $clog2(CAL_POINTS);
  localparam int PROD_W   = KX_W + DEN_W + 2;
  localparam int T_W      = DIV_W + 4;
  localparam int FAC_W    = $clog2(CAL_POINTS + 2);
  localparam int CFG_IDX_W = 3;

  localparam int MV_DIVIDEND = 1126400;
  localparam int MV_MAX      = 32767;
  localparam int MV_MIN      = MV_DIVIDEND / (MV_MAX + 1) + 1;

  localparam logic [1:0] STS_ADVANCED = 2'd0;
  localparam logic [1:0] STS_NOISE    = 2'd1;
  localparam logic [1:0] STS_DONE     = 2'd2;
  localparam logic [1:0] STS_IGNORED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_TOL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_DELTAS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOM_OFFSET = 3'd4;

  function automatic logic [7:0] seg_len(input logic [DELTAS_W-1:0] deltas, input int k);
    logic [7:0] len;
    len = 8'd0;
    if (k < SEGS) len = deltas[8*k +: 8];
    return len;
  endfunction

endpackage

>>> src/sensor_sample_linearize_average.sv
`timescale 1ns / 1ps

// Measurement sequencer for 10-bit converter samples: a start transaction (tuser 0) opens a
// cycle on the battery channel, conversions (tuser 1) walk it through discard, reference and
// confirm steps, and every transaction returns exactly one result carrying status, the channel
// for the next conversion, both running averages and the last temperature. Confirmed battery
// and temperature samples pass through the shared one-bit-per-cycle divider that forms
// millivolts, the segment interpolation and the ring averages; start, ignored, reference and
// noisy conversions do not use it. Both rings sit in one memory with a registered read port,
// cleared at reset by per-entry valid bits, so the block is ready right out of reset.
module sensor_sample_linearize_average
  import ssla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [9:0] sample
  input  logic                 in_tuser,   // [0] action
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [1:0] status, [2] channel, [17:3] battery_average, [33:18] temp_avg,
  // [49:34] last_temperature
  output logic [55:0]          out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DELTAS_W-1:0]  cfg_data
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SEG   = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_TDIV  = 9'b000001000,
    ST_TFIN  = 9'b000010000,
    ST_RD    = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_DDONE = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    DU_MV   = 2'd0,
    DU_TEMP = 2'd1,
    DU_AVG  = 2'd2
  } div_use_t;

  localparam logic [2:0] STEP_IDLE    = 3'd0;
  localparam logic [2:0] STEP_DISCARD = 3'd1;
  localparam logic [2:0] STEP_BREF    = 3'd2;
  localparam logic [2:0] STEP_BCHK    = 3'd3;
  localparam logic [2:0] STEP_TREF    = 3'd4;
  localparam logic [2:0] STEP_TCHK    = 3'd5;

  state_t st_r;
  div_use_t du_r;

  logic [7:0]          noise_tol_r;
  logic [9:0]          cal_base_r;
  logic [9:0]          cal_step_r;
  logic [DELTAS_W-1:0] cal_deltas_r;
  logic [7:0]          room_offset_r;

  logic [2:0]              step_r;
  logic [SMP_W:0]          ref_r;
  logic [SMP_W-1:0]        smp_r;
  logic [1:0]              sts_r;
  logic                    chan_r;
  logic                    ring_ch_r;
  logic [POS_W-1:0]        pos_r;
  logic [FILL_W-1:0]       fill_r;
  logic signed [SUM_W-1:0] bsum_r;
  logic signed [SUM_W-1:0] tsum_r;
  logic [14:0]             bavg_r;
  logic signed [15:0]      tavg_r;
  logic signed [15:0]      last_r;
  logic signed [15:0]      val_r;

  logic [KX_W-1:0]          kx_r;
  logic [IDX_W-1:0]         idx_r;
  logic [7:0]               d_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DIV_W:0]    qs_r;

  logic [DIV_W-1:0] div_q_r;
  logic [DEN_W-1:0] div_rem_r;
  logic [DEN_W-1:0] div_den_r;
  logic             div_neg_r;
  logic [CNT_W-1:0] div_cnt_r;

  logic [15:0]             mem [2**ADDR_W];
  logic [2**ADDR_W-1:0]    vld_r;
  logic [15:0]             rd_r;
  logic                    rd_vld_r;

  logic                 out_tvalid_r;
  logic [55:0]          out_tdata_r;

  // ---------------------------------------------------------------- combinational
  logic             in_acc;
  logic [SMP_W-1:0] smp_in;
  logic [SMP_W:0]   ndiff;
  logic [SMP_W:0]   nabs;
  logic             noisy;
  logic             mem_re;
  logic             mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic             out_free;

  assign in_tready  = (st_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign smp_in     = in_tdata[SMP_W-1:0];
  assign ndiff      = {1'b0, smp_in} - ref_r;
  assign nabs       = ndiff[SMP_W] ? (~ndiff + 1'b1) : ndiff;
  assign noisy      = nabs > {{(SMP_W-7){1'b0}}, noise_tol_r};
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign mem_re   = (in_acc && in_tuser && step_r == STEP_BCHK && !noisy) || (st_r == ST_TFIN);
  assign mem_we   = (st_r == ST_RD);
  assign mem_addr = (st_r == ST_IDLE) ? {1'b0, pos_r} : {ring_ch_r, pos_r};

  // segment search
  logic [KX_W-1:0]  kx_c;
  logic [IDX_W-1:0] idx_c;
  logic             found_c;
  always_comb begin
    kx_c    = KX_W'(cal_base_r) + KX_W'(seg_len(cal_deltas_r, 0));
    idx_c   = IDX_W'(CAL_POINTS - 1);
    found_c = 1'b0;
    for (int j = 1; j < CAL_POINTS - 1; j++) begin
      if (!found_c) begin
        if (KX_W'(smp_r) < kx_c + KX_W'(seg_len(cal_deltas_r, j))) begin
          found_c = 1'b1;
          idx_c   = IDX_W'(j);
        end else begin
          kx_c = kx_c + KX_W'(seg_len(cal_deltas_r, j));
        end
      end
    end
  end

  logic signed [KX_W:0] diff_c;
  assign diff_c = $signed({1'b0, kx_r}) - $signed({{(KX_W+1-SMP_W){1'b0}}, smp_r});

  // final temperature
  logic [FAC_W-1:0]       fac_c;
  logic [FAC_W+DEN_W-1:0] span_c;
  logic signed [T_W-1:0]  off_c;
  logic signed [T_W-1:0]  t_c;
  logic signed [15:0]     tsat_c;
  always_comb begin
    fac_c  = FAC_W'(CAL_POINTS + 1) - FAC_W'(idx_r);
    span_c = (FAC_W+DEN_W)'(fac_c) * (FAC_W+DEN_W)'(cal_step_r);
    off_c  = T_W'($signed(room_offset_r));
    t_c    = T_W'(qs_r) + T_W'($signed({1'b0, span_c})) + (off_c <<< 3) + (off_c <<< 1);
    if (t_c > T_W'(32767))       tsat_c = 16'sh7FFF;
    else if (t_c < T_W'(-32768)) tsat_c = -16'sh8000;
    else                         tsat_c = 16'(t_c);
  end

  // ring sum update
  logic signed [15:0]      old_c;
  logic signed [SUM_W:0]   sumw_c;
  logic signed [SUM_W-1:0] sum_c;
  logic signed [SUM_W-1:0] smag_c;
  always_comb begin
    old_c  = rd_vld_r ? $signed(rd_r) : 16'sd0;
    sumw_c = (SUM_W+1)'(ring_ch_r ? tsum_r : bsum_r) + (SUM_W+1)'(val_r) - (SUM_W+1)'(old_c);
    sum_c  = SUM_W'(sumw_c);
    smag_c = sum_c[SUM_W-1] ? -sum_c : sum_c;
  end

  logic signed [PROD_W-1:0] pmag_c;
  assign pmag_c = prod_r[PROD_W-1] ? -prod_r : prod_r;

  // restoring divider step
  logic [DEN_W:0]        rsh_c;
  logic                  ge_c;
  logic [DEN_W:0]        rsub_c;
  logic signed [DIV_W:0] qs_c;
  assign rsh_c  = {div_rem_r, div_q_r[DIV_W-1]};
  assign ge_c   = rsh_c >= {1'b0, div_den_r};
  assign rsub_c = rsh_c - {1'b0, div_den_r};
  assign qs_c   = div_neg_r ? -$signed({1'b0, div_q_r}) : $signed({1'b0, div_q_r});

  // ---------------------------------------------------------------- ring memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= val_r;
    if (mem_re) rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) vld_r[mem_addr] <= 1'b1;
      if (mem_re) rd_vld_r <= vld_r[mem_addr];
    end
  end

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_tol_r   <= 8'd3;
      cal_base_r    <= 10'd256;
      cal_step_r    <= 10'd500;
      cal_deltas_r  <= 56'd18085043209519168;
      room_offset_r <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_NOISE_TOL:   noise_tol_r   <= cfg_data[7:0];
        CFG_CAL_BASE:    cal_base_r    <= cfg_data[9:0];
        CFG_CAL_STEP:    cal_step_r    <= cfg_data[9:0];
        CFG_CAL_DELTAS:  cal_deltas_r  <= cfg_data;
        CFG_ROOM_OFFSET: room_offset_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      du_r         <= DU_MV;
      step_r       <= STEP_IDLE;
      ref_r        <= '0;
      pos_r        <= '0;
      fill_r       <= FILL_W'(1);
      bsum_r       <= '0;
      tsum_r       <= '0;
      bavg_r       <= '0;
      tavg_r       <= '0;
      last_r       <= '0;
      out_tvalid_r <= 1'b0;
      div_den_r    <= DEN_W'(1);
    end else begin
      if (out_tvalid_r && out_tready && st_r != ST_OUT) out_tvalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (!in_tuser) begin
              step_r <= STEP_DISCARD;
              sts_r  <= STS_ADVANCED;
              chan_r <= 1'b0;
              st_r   <= ST_OUT;
            end else begin
              case (step_r)
                STEP_DISCARD: begin
                  step_r <= STEP_BREF;
                  sts_r  <= STS_ADVANCED;
                  chan_r <= 1'b0;
                  st_r   <= ST_OUT;
                end
                STEP_BREF: begin
                  ref_r  <= {1'b0, smp_in};
                  step_r <= STEP_BCHK;
                  sts_r  <= STS_ADVANCED;
                  chan_r <= 1'b0;
                  st_r   <= ST_OUT;
                end
                STEP_BCHK: begin
                  if (noisy) begin
                    ref_r  <= {1'b0, smp_in};
                    sts_r  <= STS_NOISE;
                    chan_r <= 1'b0;
                    st_r   <= ST_OUT;
                  end else begin
                    step_r    <= STEP_TREF;
                    sts_r     <= STS_ADVANCED;
                    chan_r    <= 1'b1;
                    ring_ch_r <= 1'b0;
                    if (smp_in < SMP_W'(MV_MIN)) begin
                      val_r <= 16'(MV_MAX);
                      st_r  <= ST_RD;
                    end else begin
                      div_q_r   <= DIV_W'(MV_DIVIDEND);
                      div_rem_r <= '0;
                      div_den_r <= smp_in;
                      div_neg_r <= 1'b0;
                      div_cnt_r <= CNT_W'(DIV_W);
                      du_r      <= DU_MV;
                      st_r      <= ST_DIV;
                    end
                  end
                end
                STEP_TREF: begin
                  ref_r  <= {1'b0, smp_in};
                  step_r <= STEP_TCHK;
                  sts_r  <= STS_ADVANCED;
                  chan_r <= 1'b1;
                  st_r   <= ST_OUT;
                end
                STEP_TCHK: begin
                  if (noisy) begin
                    ref_r  <= {1'b0, smp_in};
                    sts_r  <= STS_NOISE;
                    chan_r <= 1'b1;
                    st_r   <= ST_OUT;
                  end else begin
                    step_r    <= STEP_IDLE;
                    sts_r     <= STS_DONE;
                    chan_r    <= 1'b0;
                    smp_r     <= smp_in;
                    ring_ch_r <= 1'b1;
                    st_r      <= ST_SEG;
                  end
                end
                default: begin
                  step_r <= STEP_IDLE;
                  sts_r  <= STS_IGNORED;
                  chan_r <= 1'b0;
                  st_r   <= ST_OUT;
                end
              endcase
            end
          end
        end
        ST_SEG: begin
          kx_r  <= kx_c;
          idx_r <= idx_c;
          d_r   <= seg_len(cal_deltas_r, int'(idx_c));
          st_r  <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= PROD_W'(diff_c) * PROD_W'($signed({1'b0, cal_step_r}));
          st_r   <= ST_TDIV;
        end
        ST_TDIV: begin
          if (d_r == 8'd0) begin
            // empty segment interpolates to zero
            qs_r <= '0;
            st_r <= ST_TFIN;
          end else begin
            div_q_r   <= DIV_W'(unsigned'(pmag_c));
            div_rem_r <= '0;
            div_den_r <= DEN_W'(d_r);
            div_neg_r <= prod_r[PROD_W-1];
            div_cnt_r <= CNT_W'(DIV_W);
            du_r      <= DU_TEMP;
            st_r      <= ST_DIV;
          end
        end
        ST_TFIN: begin
          last_r <= tsat_c;
          val_r  <= tsat_c;
          st_r   <= ST_RD;
        end
        ST_RD: begin
          if (ring_ch_r) tsum_r <= sum_c;
          else           bsum_r <= sum_c;
          div_q_r   <= DIV_W'(unsigned'(smag_c));
          div_rem_r <= '0;
          div_den_r <= DEN_W'(fill_r);
          div_neg_r <= sum_c[SUM_W-1];
          div_cnt_r <= CNT_W'(DIV_W);
          du_r      <= DU_AVG;
          st_r      <= ST_DIV;
        end
        ST_DIV: begin
          div_q_r   <= {div_q_r[DIV_W-2:0], ge_c};
          div_rem_r <= ge_c ? rsub_c[DEN_W-1:0] : rsh_c[DEN_W-1:0];
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == CNT_W'(1)) st_r <= ST_DDONE;
        end
        ST_DDONE: begin
          case (du_r)
            DU_MV: begin
              val_r <= 16'(div_q_r);
              st_r  <= ST_RD;
            end
            DU_TEMP: begin
              qs_r <= qs_c;
              st_r <= ST_TFIN;
            end
            default: begin
              if (ring_ch_r) begin
                tavg_r <= 16'(qs_c);
                pos_r  <= (pos_r == POS_W'(RING_DEPTH - 1)) ? '0 : pos_r + 1'b1;
                if (fill_r < FILL_W'(RING_DEPTH)) fill_r <= fill_r + 1'b1;
              end else begin
                bavg_r <= 15'(div_q_r);
              end
              st_r <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          if (out_free) begin
            out_tdata_r  <= {6'd0, last_r, tavg_r, bavg_r, chan_r, sts_r};
            out_tvalid_r <= 1'b1;
            st_r         <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (div_den_r != '0))
    else $error("divider running with zero divisor");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != '0) && (fill_r <= FILL_W'(RING_DEPTH)))
    else $error("ring fill out of range");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction taken while one is in work");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_TCHK)
    else $error("sequence step out of range");

endmodule

>>> dv/tb_sensor_sample_linearize_average.sv
`timescale 1ns / 1ps

module tb_sensor_sample_linearize_average;
  import ssla_pkg::*;

  typedef struct packed {
    logic       action;
    logic [9:0] sample;
  } conv_item_t;

  typedef struct packed {
    logic [15:0] last_temp;
    logic [15:0] temp_avg;
    logic [14:0] batt_avg;
    logic        channel;
    logic [1:0]  status;
  } meas_result_t;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_CONV  = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [55:0]          out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DELTAS_W-1:0]  cfg_data = '0;

  sensor_sample_linearize_average u_top (.*);

  always #2 clk = ~clk;

  // predictor copy of the configuration and state
  logic [7:0]          tol_q;
  logic [9:0]          base_q;
  logic [9:0]          span_q;
  logic [55:0]         deltas_q;
  logic signed [7:0]   offset_q;
  int                  seq_step;
  int                  ref_smp;
  shortint             batt_ring [RING_DEPTH];
  shortint             temp_ring [RING_DEPTH];
  int                  batt_sum;
  int                  temp_sum;
  int                  ring_slot;
  int                  ring_fill;
  shortint             batt_avg;
  shortint             temp_avg;
  shortint             last_temp;

  conv_item_t   pending_q [$];
  meas_result_t expected_q [$];
  int           errors = 0;
  bit           burst = 1'b0;
  bit           in_taken = 1'b0;
  int           in_gap = 0;
  int           out_gap = 0;

  function automatic longint seg_bytes(int k);
    if (k >= 7) return 0;
    return longint'(deltas_q[8*k +: 8]);
  endfunction

  function automatic shortint to_mv(int s);
    int mv;
    if (s <= 0) return 16'sd32767;
    mv = 1126400 / s;
    if (mv > 32767) mv = 32767;
    return shortint'(mv);
  endfunction

  function automatic shortint to_centideg(int s);
    longint kx, stp, d, t;
    int i;
    kx = longint'(base_q) + seg_bytes(0);
    stp = longint'(span_q);
    for (i = 1; i < CAL_POINTS - 1; i++) begin
      if (longint'(s) < kx + seg_bytes(i)) break;
      kx += seg_bytes(i);
    end
    d = seg_bytes(i);
    t = (d == 0) ? 0 : ((kx - longint'(s)) * stp) / d;
    t += longint'(CAL_POINTS) * stp - (longint'(i) - 1) * stp;
    t += longint'(offset_q) * 10;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return shortint'(t);
  endfunction

  function automatic bit is_noisy(int s);
    int diff;
    diff = s - ref_smp;
    if (diff < 0) diff = -diff;
    return diff > int'(tol_q);
  endfunction

  function automatic meas_result_t predict_measurement(conv_item_t it);
    meas_result_t r;
    int s, p;
    s = int'(it.sample);
    p = ring_slot % RING_DEPTH;
    r = '0;
    if (it.action == ACT_START) begin
      seq_step = 1;
    end else begin
      case (seq_step)
        1: seq_step = 2;
        2: begin
          ref_smp = s;
          seq_step = 3;
        end
        3: begin
          if (is_noisy(s)) begin
            ref_smp = s;
            r.status = STS_NOISE;
          end else begin
            batt_sum += int'(to_mv(s)) - int'(batt_ring[p]);
            batt_ring[p] = to_mv(s);
            batt_avg = shortint'(batt_sum / ring_fill);
            seq_step = 4;
            r.channel = 1'b1;
          end
        end
        4: begin
          ref_smp = s;
          seq_step = 5;
          r.channel = 1'b1;
        end
        5: begin
          if (is_noisy(s)) begin
            ref_smp = s;
            r.status = STS_NOISE;
            r.channel = 1'b1;
          end else begin
            last_temp = to_centideg(s);
            temp_sum += int'(last_temp) - int'(temp_ring[p]);
            temp_ring[p] = last_temp;
            temp_avg = shortint'(temp_sum / ring_fill);
            ring_slot = (ring_slot + 1) % RING_DEPTH;
            if (ring_fill < RING_DEPTH) ring_fill++;
            seq_step = 0;
            r.status = STS_DONE;
          end
        end
        default: begin
          seq_step = 0;
          r.status = STS_IGNORED;
        end
      endcase
    end
    r.batt_avg = batt_avg[14:0];
    r.temp_avg = temp_avg;
    r.last_temp = last_temp;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // input side: accept at rising edge, drive at falling edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_q.push_back(predict_measurement({in_tuser, in_tdata[9:0]}));
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    conv_item_t it;
    if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        in_tuser <= it.action;
        in_tdata <= {6'd0, it.sample};
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    meas_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[49:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status || got.channel !== want.channel ||
            got.batt_avg !== want.batt_avg || got.temp_avg !== want.temp_avg ||
            got.last_temp !== want.last_temp || out_tdata[55:50] !== 6'd0) begin
          $display("%0t: mismatch exp sts=%0d ch=%0d bat=%0d tavg=%0d last=%0d",
                   $time, want.status, want.channel, want.batt_avg,
                   $signed(want.temp_avg), $signed(want.last_temp));
          $display("%0t:          got sts=%0d ch=%0d bat=%0d tavg=%0d last=%0d pad=%h",
                   $time, got.status, got.channel, got.batt_avg,
                   $signed(got.temp_avg), $signed(got.last_temp), out_tdata[55:50]);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [55:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NOISE_TOL:   tol_q = val[7:0];
      CFG_CAL_BASE:    base_q = val[9:0];
      CFG_CAL_STEP:    span_q = val[9:0];
      CFG_CAL_DELTAS:  deltas_q = val;
      CFG_ROOM_OFFSET: offset_q = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(logic act, int s);
    pending_q.push_back({act, 10'(s)});
  endtask

  function automatic int clamp_smp(int s);
    if (s < 0) return 0;
    if (s > 1023) return 1023;
    return s;
  endfunction

  // one confirmed read: reference, optional random rereads, then a sample close to the last one
  task automatic push_read(int center, int spread);
    int r;
    r = clamp_smp(center + $urandom_range(0, 2 * spread) - spread);
    push_item(ACT_CONV, r);
    while ($urandom_range(0, 4) == 0) begin
      r = $urandom_range(0, 1023);
      push_item(ACT_CONV, r);
    end
    push_item(ACT_CONV, clamp_smp(r + $urandom_range(0, 2 * tol_q) - int'(tol_q)));
  endtask

  task automatic push_cycle();
    int hi;
    push_item(ACT_START, $urandom_range(0, 1023));
    push_item(ACT_CONV, $urandom_range(0, 1023));
    if ($urandom_range(0, 9) == 0) push_read($urandom_range(0, 1) ? 0 : 40, 6);
    else push_read($urandom_range(0, 1023), 0);
    hi = int'(base_q) + int'(deltas_q[7:0]) + int'(deltas_q[15:8]) + int'(deltas_q[23:16])
       + int'(deltas_q[31:24]) + int'(deltas_q[39:32]) + int'(deltas_q[47:40]) + 30;
    if ($urandom_range(0, 3) == 0) push_read($urandom_range(0, 1023), 0);
    else push_read($urandom_range(int'(base_q), hi), 20);
  endtask

  task automatic run_phase(int n);
    int base_sz;
    burst = ($urandom_range(0, 3) == 0);
    base_sz = pending_q.size();
    while (pending_q.size() - base_sz < n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(1'($urandom_range(0, 1)), $urandom_range(0, 1023));
      end else begin
        push_cycle();
      end
    end
    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int ph;
    tol_q = 8'd3;
    base_q = 10'd256;
    span_q = 10'd500;
    deltas_q = 56'd18085043209519168;
    offset_q = 8'sd0;
    seq_step = 0;
    ref_smp = 0;
    for (int k = 0; k < RING_DEPTH; k++) begin
      batt_ring[k] = 0;
      temp_ring[k] = 0;
    end
    batt_sum = 0;
    temp_sum = 0;
    ring_slot = 0;
    ring_fill = 1;
    batt_avg = 0;
    temp_avg = 0;
    last_temp = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle conversion, restart mid-cycle, zero and small battery
    // samples, noisy repeats, extreme temperature samples
    push_item(ACT_CONV, 1023);
    push_item(ACT_START, 0);
    push_item(ACT_CONV, 5);
    push_item(ACT_START, 1023);
    push_item(ACT_CONV, 0);
    push_item(ACT_CONV, 0);
    push_item(ACT_CONV, 0);
    push_item(ACT_CONV, 0);
    push_item(ACT_CONV, 1023);
    push_item(ACT_CONV, 1020);
    push_item(ACT_CONV, 0);
    push_item(ACT_START, 0);
    push_item(ACT_CONV, 1);
    push_item(ACT_CONV, 34);
    push_item(ACT_CONV, 300);
    push_item(ACT_CONV, 35);
    push_item(ACT_CONV, 1023);
    push_item(ACT_CONV, 1023);
    push_item(ACT_CONV, 700);
    push_item(ACT_START, 0);
    push_item(ACT_CONV, 9);
    push_item(ACT_CONV, 1023);
    push_item(ACT_CONV, 1023);
    push_item(ACT_CONV, 0);
    push_item(ACT_CONV, 3);
    run_phase(0);
    run_phase(200);

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_NOISE_TOL, 56'd0);
          write_reg(CFG_CAL_BASE, 56'd0);
          write_reg(CFG_CAL_STEP, 56'd1);
          write_reg(CFG_CAL_DELTAS, 56'd0);
          write_reg(CFG_ROOM_OFFSET, 56'h80);
        end
        1: begin
          write_reg(CFG_NOISE_TOL, 56'd255);
          write_reg(CFG_CAL_BASE, 56'd1023);
          write_reg(CFG_CAL_STEP, 56'd1000);
          write_reg(CFG_CAL_DELTAS, {56{1'b1}});
          write_reg(CFG_ROOM_OFFSET, 56'h7f);
        end
        2: begin
          write_reg(CFG_CAL_BASE, 56'd0);
          write_reg(CFG_CAL_STEP, 56'd1);
          write_reg(CFG_CAL_DELTAS, {56{1'b1}});
          write_reg(CFG_NOISE_TOL, 56'd2);
        end
        default: begin
          write_reg(CFG_NOISE_TOL, 56'($urandom_range(0, 40)));
          write_reg(CFG_CAL_BASE, 56'($urandom_range(0, 1023)));
          write_reg(CFG_CAL_STEP, 56'($urandom_range(1, 1000)));
          write_reg(CFG_CAL_DELTAS, 56'({$urandom(), $urandom()}) &
                    {$urandom_range(0, 1) ? 8'h0 : 8'hff, {48{1'b1}}});
          write_reg(CFG_ROOM_OFFSET, 56'($urandom_range(0, 255)));
        end
      endcase
      run_phase(180);
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> files.f
src/ssla_pkg.sv
src/sensor_sample_linearize_average.sv
dv/tb_sensor_sample_linearize_average.sv
